FILE: rtl/go_back_n_sender_assert.svh
// Assertion macros for the go-back-n sender blocks.
// GBN_ASSERT is checked outside reset; GBN_ASSERT_RST is checked on every edge.
`ifndef GO_BACK_N_SENDER_ASSERT_SVH
`define GO_BACK_N_SENDER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define GBN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define GBN_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GBN_ASSERT(lbl, prop, msg)
`define GBN_ASSERT_RST(lbl, prop, msg)
`endif
`endif

FILE: rtl/gbn_pkg.sv
package gbn_pkg;

  localparam int BUF_DEPTH  = 64;
  localparam int MSG_WORDS  = 5;
  localparam int SEQ_BITS   = 16;
  localparam int SLOT_BITS  = $clog2(BUF_DEPTH);
  localparam int ADDR_BITS  = $clog2(BUF_DEPTH * MSG_WORDS);
  localparam int WIDX_BITS  = 3;
  localparam int SUM_BITS   = 13;
  localparam int WIN_BITS   = 4;
  localparam int WIN_MAX    = 12;
  localparam int TMO_BITS   = 16;
  localparam int CFG_BITS   = 16;

  // input op codes; OP_RSVD is accepted and ignored
  localparam logic [1:0] OP_MSG  = 2'd0;
  localparam logic [1:0] OP_ACK  = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;
  localparam logic [1:0] OP_RSVD = 2'd3;

  // result kinds
  localparam logic [2:0] KIND_WORD    = 3'd0;
  localparam logic [2:0] KIND_ACK_OK  = 3'd1;
  localparam logic [2:0] KIND_ACK_BAD = 3'd2;
  localparam logic [2:0] KIND_HELD    = 3'd3;
  localparam logic [2:0] KIND_DROP    = 3'd4;

  // configuration register indexes
  localparam logic CFG_WINDOW  = 1'b0;
  localparam logic CFG_TIMEOUT = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SINGLE,
    S_SUM,
    S_CK,
    S_RD,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic emit_single;
    logic sum_rd;
    logic ck_load;
    logic word_rd;
    logic emit_word;
  } gbn_cmd_t;

  typedef struct packed {
    logic start_single;
    logic start_packets;
    logic word_last;
    logic pkt_last;
    logic out_free;
  } gbn_stat_t;

endpackage

FILE: rtl/gbn_if.sv
interface gbn_in_if import gbn_pkg::*; ;
  logic                valid;
  logic                ready;
  logic [1:0]          op;
  logic [SEQ_BITS-1:0] in_seq;
  logic [SEQ_BITS-1:0] in_ack;
  logic signed [31:0]  in_checksum;
  logic [31:0]         payload_word;

  modport source(output valid, op, in_seq, in_ack, in_checksum, payload_word, input ready);
  modport sink(input valid, op, in_seq, in_ack, in_checksum, payload_word, output ready);
endinterface

interface gbn_out_if import gbn_pkg::*; ;
  logic                 valid;
  logic                 ready;
  logic [2:0]           kind;
  logic [SEQ_BITS-1:0]  out_seq;
  logic [SEQ_BITS-1:0]  out_ack;
  logic signed [31:0]   out_checksum;
  logic [WIDX_BITS-1:0] word_index;
  logic [31:0]          out_word;
  logic                 packet_end;
  logic                 run_end;

  modport source(output valid, kind, out_seq, out_ack, out_checksum, word_index, out_word,
                 packet_end, run_end, input ready);
  modport sink(input valid, kind, out_seq, out_ack, out_checksum, word_index, out_word,
               packet_end, run_end, output ready);
endinterface

FILE: rtl/go_back_n_sender.sv
// Go-back-N sender.
// in_item carries message words, acknowledgement words and timer ticks (op);
// an item moves when valid and ready are high at a rising edge of clk.
// out_item carries results: packet words, ack accepted or rejected, message
// held, message dropped; run_end marks the last result of one input item.
// The config port (cfg_we, cfg_index, cfg_data) writes window_size (index 0)
// and timeout_ticks (index 1); the user writes it only while the block is
// idle, which the block itself does not enforce.
// An item with no result leaves the controller in S_IDLE; an item with a
// single result waits in S_SINGLE until out_item is free. A sent packet
// passes S_SUM and S_CK, then S_RD and S_EMIT for each of its 5 words, set
// by the single read port of the message store (one word read, then one
// word loaded into the output register); a timeout resend repeats this for
// each packet in flight, up to 12; results load from S_SINGLE or S_EMIT.
// Reset (rst, synchronous) restores window 8, timeout 40, sequence numbers 1
// and a stopped timer; the stores need no clearing pass.
// A stalled receiver holds the output register; the sender waits and drops
// nothing, and takes no new item until the current item's results are out.
module go_back_n_sender import gbn_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [CFG_BITS-1:0] cfg_data,
  gbn_in_if.sink              in_item,
  gbn_out_if.source           out_item
);

  gbn_cmd_t  cmd;
  gbn_stat_t stat;

  // controller: sequences accept, single result, and packet word reads
  gbn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_item.valid),
    .in_ready (in_item.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: protocol state, message store, checksum and output register
  gbn_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .op           (in_item.op),
    .in_seq       (in_item.in_seq),
    .in_ack       (in_item.in_ack),
    .in_checksum  (in_item.in_checksum),
    .payload_word (in_item.payload_word),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (out_item.valid),
    .out_ready    (out_item.ready),
    .kind         (out_item.kind),
    .out_seq      (out_item.out_seq),
    .out_ack      (out_item.out_ack),
    .out_checksum (out_item.out_checksum),
    .word_index   (out_item.word_index),
    .out_word     (out_item.out_word),
    .packet_end   (out_item.packet_end),
    .run_end      (out_item.run_end)
  );

endmodule

FILE: rtl/gbn_ctrl.sv
`include "go_back_n_sender_assert.svh"
module gbn_ctrl import gbn_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  gbn_stat_t stat,
  output gbn_cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (stat.start_single) begin
            state_next = S_SINGLE;
          end else if (stat.start_packets) begin
            state_next = S_SUM;
          end
        end
      end
      S_SINGLE: begin
        if (stat.out_free) begin
          cmd.emit_single = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_SUM: begin
        cmd.sum_rd = 1'b1;
        state_next = S_CK;
      end
      S_CK: begin
        cmd.ck_load = 1'b1;
        state_next  = S_RD;
      end
      S_RD: begin
        cmd.word_rd = 1'b1;
        state_next  = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit_word = 1'b1;
          if (!stat.word_last) begin
            state_next = S_RD;
          end else if (stat.pkt_last) begin
            state_next = S_IDLE;
          end else begin
            state_next = S_SUM;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  `GBN_ASSERT(a_one_load, !(cmd.emit_word && cmd.emit_single), "two output loads")
  `GBN_ASSERT(a_load_free, (cmd.emit_word || cmd.emit_single) |-> stat.out_free, "overwrite")
  `GBN_ASSERT(a_start_excl, cmd.accept |-> !(stat.start_single && stat.start_packets), "both")
  `GBN_ASSERT(a_sum_ck, (state == S_SUM) |=> (state == S_CK), "sum read not followed")
  `GBN_ASSERT_RST(a_rst_idle, rst |=> (state == S_IDLE), "not idle after reset")

endmodule

FILE: rtl/gbn_dp.sv
module gbn_dp import gbn_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_BITS-1:0]   cfg_data,
  input  logic [1:0]            op,
  input  logic [SEQ_BITS-1:0]   in_seq,
  input  logic [SEQ_BITS-1:0]   in_ack,
  input  logic signed [31:0]    in_checksum,
  input  logic [31:0]           payload_word,
  input  gbn_cmd_t              cmd,
  output gbn_stat_t             stat,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2:0]            kind,
  output logic [SEQ_BITS-1:0]   out_seq,
  output logic [SEQ_BITS-1:0]   out_ack,
  output logic signed [31:0]    out_checksum,
  output logic [WIDX_BITS-1:0]  word_index,
  output logic [31:0]           out_word,
  output logic                  packet_end,
  output logic                  run_end
);

  logic [WIN_BITS-1:0]  window_size;
  logic [TMO_BITS-1:0]  timeout_ticks;
  logic [SEQ_BITS-1:0]  window_base, next_seq, peer_ack, cur_seq;
  logic [TMO_BITS-1:0]  timer_count;
  logic                 timer_running;
  logic [WIDX_BITS-1:0] word_count, ack_words, widx;
  logic signed [SUM_BITS-1:0] partial_sum, ack_sum, sum_q;
  logic                 zero_seen, drop_pending;
  logic [WIN_BITS-1:0]  pkts_left;
  logic [31:0]          ck, word_q;
  logic [2:0]           s_kind;
  logic [SEQ_BITS-1:0]  s_seq, s_ack;

  logic [31:0]               payload_mem [BUF_DEPTH*MSG_WORDS];
  logic signed [SUM_BITS-1:0] sum_mem [BUF_DEPTH];

  logic [WIN_BITS-1:0]  eff_w, outst;
  logic [SEQ_BITS-1:0]  span;
  logic                 in_win, msg_first, msg_last, drop, zs;
  logic [31:0]          clean;
  logic signed [SUM_BITS-1:0] psum, asum;
  logic [7:0]           bv;
  logic [ADDR_BITS-1:0] wr_addr, rd_addr;
  logic                 ack_last, ack_ok;
  logic [31:0]          expect_ck;
  logic [TMO_BITS-1:0]  limit, cnt1;
  logic                 expire;

  always_comb begin
    if (window_size == '0) begin
      eff_w = WIN_BITS'(1);
    end else if (window_size > WIN_BITS'(WIN_MAX)) begin
      eff_w = WIN_BITS'(WIN_MAX);
    end else begin
      eff_w = window_size;
    end
    span   = next_seq - window_base;
    outst  = (span < SEQ_BITS'(eff_w)) ? span[WIN_BITS-1:0] : eff_w;
    in_win = span < SEQ_BITS'(eff_w);

    msg_first = (word_count == '0);
    msg_last  = (op == OP_MSG) && (word_count == WIDX_BITS'(MSG_WORDS - 1));
    drop      = msg_first ? (span >= SEQ_BITS'(BUF_DEPTH)) : drop_pending;
    zs        = msg_first ? 1'b0 : zero_seen;
    psum      = msg_first ? '0 : partial_sum;
    clean     = '0;
    for (int b = 0; b < 4; b++) begin
      bv = payload_word[8*b +: 8];
      if (zs) begin
        bv = 8'd0;
      end else if (bv == 8'd0) begin
        zs = 1'b1;
      end
      clean[8*b +: 8] = bv;
      psum = psum + SUM_BITS'(signed'(bv));
    end

    asum = (ack_words == '0) ? '0 : ack_sum;
    for (int b = 0; b < 4; b++) begin
      asum = asum + SUM_BITS'(signed'(payload_word[8*b +: 8]));
    end
    ack_last  = (op == OP_ACK) && (ack_words == WIDX_BITS'(MSG_WORDS - 1));
    expect_ck = 32'(asum) + 32'(in_seq) + 32'(in_ack);
    ack_ok    = (expect_ck == 32'(in_checksum)) &&
                ((in_ack - window_base) < SEQ_BITS'(outst));

    limit  = (timeout_ticks == '0) ? TMO_BITS'(1) : timeout_ticks;
    cnt1   = timer_count + TMO_BITS'(1);
    expire = cnt1 >= limit;

    wr_addr = ADDR_BITS'(next_seq[SLOT_BITS-1:0]) * ADDR_BITS'(MSG_WORDS) +
              ADDR_BITS'(word_count);
    rd_addr = ADDR_BITS'(cur_seq[SLOT_BITS-1:0]) * ADDR_BITS'(MSG_WORDS) + ADDR_BITS'(widx);

    stat.start_single  = (msg_last && (drop || !in_win)) || ack_last;
    stat.start_packets = (msg_last && !drop && in_win) ||
                         ((op == OP_TICK) && timer_running && expire && (outst != '0));
    stat.word_last     = (widx == WIDX_BITS'(MSG_WORDS - 1));
    stat.pkt_last      = (pkts_left == WIN_BITS'(1));
    stat.out_free      = !out_valid || out_ready;
  end

  // protocol state
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size   <= WIN_BITS'(8);
      timeout_ticks <= TMO_BITS'(40);
      window_base   <= SEQ_BITS'(1);
      next_seq      <= SEQ_BITS'(1);
      peer_ack      <= SEQ_BITS'(1);
      timer_count   <= '0;
      timer_running <= 1'b0;
      word_count    <= '0;
      ack_words     <= '0;
      partial_sum   <= '0;
      ack_sum       <= '0;
      zero_seen     <= 1'b0;
      drop_pending  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_WINDOW:  window_size   <= cfg_data[WIN_BITS-1:0];
          CFG_TIMEOUT: timeout_ticks <= cfg_data[TMO_BITS-1:0];
          default: ;
        endcase
      end
      if (cmd.accept) begin
        case (op)
          OP_MSG: begin
            partial_sum <= psum;
            if (msg_last) begin
              word_count   <= '0;
              zero_seen    <= 1'b0;
              drop_pending <= 1'b0;
              if (!drop) begin
                next_seq <= next_seq + SEQ_BITS'(1);
                if (in_win && !timer_running) begin
                  timer_running <= 1'b1;
                  timer_count   <= '0;
                end
              end
            end else begin
              word_count   <= word_count + WIDX_BITS'(1);
              zero_seen    <= zs;
              drop_pending <= drop;
            end
          end
          OP_ACK: begin
            ack_sum <= asum;
            if (ack_last) begin
              ack_words <= '0;
              if (ack_ok) begin
                window_base   <= in_ack + SEQ_BITS'(1);
                peer_ack      <= in_seq;
                timer_count   <= '0;
                timer_running <= (next_seq != in_ack + SEQ_BITS'(1));
              end
            end else begin
              ack_words <= ack_words + WIDX_BITS'(1);
            end
          end
          OP_TICK: begin
            if (timer_running) begin
              if (expire) begin
                timer_count   <= '0;
                timer_running <= (outst != '0);
              end else begin
                timer_count <= cnt1;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  // send sequencing and result payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      if (op == OP_TICK) begin
        cur_seq   <= window_base;
        pkts_left <= outst;
      end else begin
        cur_seq   <= next_seq;
        pkts_left <= WIN_BITS'(1);
      end
      if (op == OP_ACK) begin
        s_kind <= ack_ok ? KIND_ACK_OK : KIND_ACK_BAD;
        s_seq  <= in_seq;
        s_ack  <= in_ack;
      end else if (drop) begin
        s_kind <= KIND_DROP;
        s_seq  <= '0;
        s_ack  <= '0;
      end else begin
        s_kind <= KIND_HELD;
        s_seq  <= next_seq;
        s_ack  <= '0;
      end
    end
    if (cmd.sum_rd) begin
      widx <= '0;
    end
    if (cmd.ck_load) begin
      ck <= 32'(sum_q) + 32'(cur_seq) + 32'(peer_ack);
    end
    if (cmd.emit_word) begin
      if (stat.word_last) begin
        widx      <= '0;
        cur_seq   <= cur_seq + SEQ_BITS'(1);
        pkts_left <= pkts_left - WIN_BITS'(1);
      end else begin
        widx <= widx + WIDX_BITS'(1);
      end
    end
  end

  // message store and per-slot sums
  always_ff @(posedge clk) begin
    if (cmd.accept && (op == OP_MSG) && !drop) begin
      payload_mem[wr_addr] <= clean;
    end
    if (cmd.accept && msg_last && !drop) begin
      sum_mem[next_seq[SLOT_BITS-1:0]] <= psum;
    end
    if (cmd.sum_rd) begin
      sum_q <= sum_mem[cur_seq[SLOT_BITS-1:0]];
    end
    if (cmd.word_rd) begin
      word_q <= payload_mem[rd_addr];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_word || cmd.emit_single) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_word) begin
      kind         <= KIND_WORD;
      out_seq      <= cur_seq;
      out_ack      <= peer_ack;
      out_checksum <= signed'(ck);
      word_index   <= widx;
      out_word     <= word_q;
      packet_end   <= stat.word_last;
      run_end      <= stat.word_last && stat.pkt_last;
    end else if (cmd.emit_single) begin
      kind         <= s_kind;
      out_seq      <= s_seq;
      out_ack      <= s_ack;
      out_checksum <= '0;
      word_index   <= '0;
      out_word     <= '0;
      packet_end   <= 1'b0;
      run_end      <= 1'b1;
    end
  end

endmodule

FILE: tb/go_back_n_sender_tb.sv
module go_back_n_sender_tb import gbn_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  // Expected result of the sender, one per output item.
  typedef struct packed {
    logic [2:0]          kind;
    logic [SEQ_BITS-1:0] seq;
    logic [SEQ_BITS-1:0] ack;
    logic [31:0]         checksum;
    logic [2:0]          widx;
    logic [31:0]         word;
    logic                pend;
    logic                rend;
  } gbn_result_t;

  // Predictor of the sender plus the queue of results it still owes.
  class gbn_scoreboard;
    logic [31:0]         store [BUF_DEPTH*MSG_WORDS];
    int                  slot_total [BUF_DEPTH];
    logic [SEQ_BITS-1:0] base, nseq, peer_ack;
    logic [15:0]         tcount;
    bit                  trun;
    int                  wcount, psum, acount, asum;
    bit                  zseen, dropping;
    logic [3:0]          win;
    logic [15:0]         tmo;
    gbn_result_t         pending [$];
    int                  errors;

    function void reset_state();
      base = 1; nseq = 1; peer_ack = 1; tcount = 0; trun = 0;
      wcount = 0; psum = 0; zseen = 0; dropping = 0; acount = 0; asum = 0;
      win = 8; tmo = 40;
      pending.delete();
    endfunction

    function int eff_win();
      if (win == 0) return 1;
      if (win > WIN_MAX) return WIN_MAX;
      return win;
    endfunction

    function int in_flight();
      logic [SEQ_BITS-1:0] span;
      span = nseq - base;
      return (span < eff_win()) ? span : eff_win();
    endfunction

    function int sbyte(logic [7:0] b);
      return $signed(b);
    endfunction

    function void push(logic [2:0] k, logic [15:0] s, logic [15:0] a, logic [31:0] c,
                       logic [2:0] i, logic [31:0] w, logic p);
      gbn_result_t r;
      r = '{k, s, a, c, i, w, p, 1'b0};
      pending.push_back(r);
    endfunction

    function void send_packet(logic [15:0] s);
      int slot;
      logic [31:0] ck;
      slot = s % BUF_DEPTH;
      ck = slot_total[slot] + s + peer_ack;
      for (int i = 0; i < MSG_WORDS; i++)
        push(KIND_WORD, s, peer_ack, ck, 3'(i), store[slot*MSG_WORDS+i], i == MSG_WORDS-1);
    endfunction

    // Note an accepted input item and append the results it causes.
    function void note_input(logic [1:0] op, logic [15:0] iseq, logic [15:0] iack,
                             logic [31:0] ick, logic [31:0] pw);
      int prior_size, slot, n;
      logic [7:0] b;
      logic [31:0] clean;
      logic [15:0] s, lim;
      bit ok;
      prior_size = pending.size();
      case (op)
        OP_MSG: begin
          slot = nseq % BUF_DEPTH;
          if (wcount == 0) begin
            dropping = (16'(nseq - base)) >= BUF_DEPTH;
            psum = 0;
            zseen = 0;
          end
          clean = 0;
          for (int k = 0; k < 4; k++) begin
            b = pw[8*k +: 8];
            if (zseen) b = 0;
            else if (b == 0) zseen = 1;
            clean[8*k +: 8] = b;
            psum += sbyte(b);
          end
          if (!dropping) store[slot*MSG_WORDS+wcount] = clean;
          wcount++;
          if (wcount == MSG_WORDS) begin
            wcount = 0;
            zseen = 0;
            if (dropping) begin
              dropping = 0;
              push(KIND_DROP, 0, 0, 0, 0, 0, 0);
            end else begin
              slot_total[slot] = psum;
              s = nseq;
              nseq = 16'(nseq + 1);
              if (16'(s - base) < eff_win()) begin
                if (!trun) begin
                  trun = 1;
                  tcount = 0;
                end
                send_packet(s);
              end else push(KIND_HELD, s, 0, 0, 0, 0, 0);
            end
          end
        end
        OP_ACK: begin
          if (acount == 0) asum = 0;
          for (int k = 0; k < 4; k++) asum += sbyte(pw[8*k +: 8]);
          acount++;
          if (acount == MSG_WORDS) begin
            acount = 0;
            ok = (32'(asum) + iseq + iack == ick) && (16'(iack - base) < in_flight());
            if (ok) begin
              base = 16'(iack + 1);
              peer_ack = iseq;
              tcount = 0;
              trun = in_flight() > 0;
            end
            push(ok ? KIND_ACK_OK : KIND_ACK_BAD, iseq, iack, 0, 0, 0, 0);
          end
        end
        OP_TICK: begin
          if (trun) begin
            lim = (tmo == 0) ? 16'd1 : tmo;
            tcount = 16'(tcount + 1);
            if (tcount >= lim) begin
              n = in_flight();
              for (int i = 0; i < n; i++) send_packet(16'(base + i));
              tcount = 0;
              trun = n > 0;
            end
          end
        end
        default: ;
      endcase
      if (pending.size() > prior_size) pending[pending.size()-1].rend = 1;
    endfunction

    // Compare one output item with the oldest expectation.
    function void check_result(gbn_result_t got);
      gbn_result_t exp_r;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
        return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p got %p", exp_r, got);
      end
    endfunction
  endclass

  logic clk, rst;
  logic cfg_we, cfg_index;
  logic [CFG_BITS-1:0] cfg_data;
  gbn_in_if  in_item ();
  gbn_out_if out_item ();
  gbn_scoreboard board;
  int cycles = 0;

  go_back_n_sender uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_item(in_item.sink), .out_item(out_item.source)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Receiver: stall on its own pattern (phase-varying mode), check results.
  int stall_mode;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst) begin
      out_item.ready <= 0;
    end else begin
      if (out_item.valid && out_item.ready)
        board.check_result('{out_item.kind, out_item.out_seq, out_item.out_ack,
                             out_item.out_checksum, out_item.word_index, out_item.out_word,
                             out_item.packet_end, out_item.run_end});
      case (stall_mode)
        0: out_item.ready <= 1;
        1: out_item.ready <= ($urandom_range(0, 3) != 0);
        default: out_item.ready <= cycles[2];
      endcase
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (cycles > 2000000) begin
        $display("[go_back_n_sender] ERROR");
        $finish;
      end
    end
  end

  int burst_left;

  // Send one item: hold valid until accepted; gaps come between bursts.
  task send_item(logic [1:0] op, logic [15:0] s, logic [15:0] a, logic [31:0] c,
                 logic [31:0] w);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_item.valid <= 0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_item.valid <= 1;
    in_item.op <= op;
    in_item.in_seq <= s;
    in_item.in_ack <= a;
    in_item.in_checksum <= c;
    in_item.payload_word <= w;
    do @(posedge clk); while (!in_item.ready);
    board.note_input(op, s, a, c, w);
  endtask

  task send_message(logic [31:0] first_word, bit rand_words);
    for (int i = 0; i < MSG_WORDS; i++)
      send_item(OP_MSG, 16'($urandom), 16'($urandom), $urandom,
                i == 0 ? first_word : (rand_words ? $urandom : 32'h01010101 * (i+1)));
  endtask

  // Build an ack with a chosen number; good=0 corrupts the checksum.
  task send_acknowledgement(logic [15:0] num, bit good);
    logic [31:0] words [MSG_WORDS];
    int total;
    logic [15:0] s;
    total = 0;
    s = 16'($urandom);
    for (int i = 0; i < MSG_WORDS; i++) begin
      words[i] = $urandom;
      for (int k = 0; k < 4; k++) total += $signed(words[i][8*k +: 8]);
    end
    for (int i = 0; i < MSG_WORDS; i++)
      send_item(OP_ACK, s, num, 32'(total) + s + num + (good ? 0 : 1), words[i]);
  endtask

  task tick_item();
    send_item(OP_TICK, 16'($urandom), 16'($urandom), $urandom, $urandom);
  endtask

  // Drain all expectations, then idle through the longest resend.
  task drain();
    in_item.valid <= 0;
    burst_left = 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task write_reg(logic idx, logic [15:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == CFG_WINDOW) board.win = val[3:0];
    else board.tmo = val;
    @(posedge clk);
  endtask

  task random_phase(int count);
    int r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 45) send_message($urandom, 1);
      else if (r < 70) send_acknowledgement(16'(board.base + $urandom_range(0, 12)), r < 66);
      else if (r < 95) tick_item();
      else send_item(OP_RSVD, 16'($urandom), 16'($urandom), $urandom, $urandom);
    end
  endtask

  initial begin
    board = new();
    board.reset_state();
    board.errors = 0;
    stall_mode = 0;
    burst_left = 0;
    rst = 1;
    cfg_we = 0; cfg_index = 0; cfg_data = 0;
    in_item.valid = 0; in_item.op = 0; in_item.in_seq = 0; in_item.in_ack = 0;
    in_item.in_checksum = 0; in_item.payload_word = 0;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: extreme bytes, zero truncation, held, ack good/bad, timeout.
    write_reg(CFG_WINDOW, 1);
    write_reg(CFG_TIMEOUT, 2);
    send_message(32'hFF80_7F01, 0);
    send_message(32'h1200_3456, 1);
    send_acknowledgement(1, 0);
    send_acknowledgement(5, 1);
    tick_item();
    tick_item();
    send_acknowledgement(1, 1);
    tick_item();
    tick_item();
    send_item(OP_RSVD, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drain();

    // Random phases over several settings, including window 0, 15 and timeout 0.
    for (int ph = 0; ph < 6; ph++) begin
      stall_mode = ph % 3;
      case (ph)
        0: begin write_reg(CFG_WINDOW, 12); write_reg(CFG_TIMEOUT, 3); end
        1: begin write_reg(CFG_WINDOW, 0);  write_reg(CFG_TIMEOUT, 0); end
        2: begin write_reg(CFG_WINDOW, 15); write_reg(CFG_TIMEOUT, 65535); end
        3: begin write_reg(CFG_WINDOW, 4);  write_reg(CFG_TIMEOUT, 1); end
        4: begin write_reg(CFG_WINDOW, 8);  write_reg(CFG_TIMEOUT, 5); end
        default: begin write_reg(CFG_WINDOW, 3); write_reg(CFG_TIMEOUT, 2); end
      endcase
      random_phase(ph == 5 ? 4 : 3);
      drain();
    end

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("[go_back_n_sender] OK");
    end else begin
      $display("[go_back_n_sender] ERROR");
    end
    $finish;
  end
endmodule
